[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and codes of the text console writer: the input and result
// beat structs, command codes and the character codes with special handling.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Command codes
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Character codes
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;

  // Cell value after reset: space in light grey on black
  localparam logic [7:0]  RESET_COLOR = 8'h07;
  localparam logic [15:0] CLEAR_CELL  = {RESET_COLOR, SPACE_CODE};

  // Input beat
  typedef struct packed {
    logic        command;
    logic [7:0]  char_code;
    logic [10:0] read_index;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic        cell_written;
    logic [10:0] cell_index;
    logic [15:0] cell_data;
    logic        scrolled;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [15:0] read_data;
  } out_beat_t;

endpackage

[rtl/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: cursor, attribute register and a screen cell store.
// ----------------------------------------------------------------------------
// After reset the block sweeps the store to spaces with attribute 0x07, one
// cell a cycle; in_ready stays low meanwhile, while cfg writes are taken at
// any time. A read or a put without scroll passes through accept, store
// access and the result register in turn; the next input beat is taken only
// once the block is back in idle. A put that finds the cursor one row past the
// bottom first scrolls through the single store port pair, one cell moved a
// cycle, then writes the last pending cell and clears the bottom row one cell
// a cycle. A new beat is taken while the previous result still waits on
// out_ready.
// ----------------------------------------------------------------------------
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(SCREEN_HEIGHT + 1);
  localparam int COL_W      = $clog2(SCREEN_WIDTH);
  localparam int IDX_W      = (ADDR_W > 11) ? ADDR_W : 11;

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] FILL_START = ADDR_W'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(SCREEN_WIDTH);
  localparam logic [ROW_W-1:0]  ROW_PEND   = ROW_W'(SCREEN_HEIGHT);
  localparam logic [ROW_W-1:0]  ROW_BOTTOM = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(SCREEN_WIDTH - 1);

  // Sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCROLL = 3'd2;
  localparam logic [2:0] ST_FILL   = 3'd3;
  localparam logic [2:0] ST_PUT    = 3'd4;
  localparam logic [2:0] ST_READ   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]        state_r;
  logic [ADDR_W-1:0] cnt_r;
  logic              pend_r;
  logic [ADDR_W-1:0] pend_addr_r;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic [7:0]        color_r;
  logic [7:0]        char_r;
  logic              rd_ok_r;
  logic              scrolled_r;
  out_beat_t         res_r;
  out_beat_t         out_r;
  logic              out_valid_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  logic              accept;
  logic [IDX_W:0]    rd_wide;
  logic              rd_in_range;
  logic              put_char;
  logic [ADDR_W-1:0] put_idx;
  logic [ROW_W-1:0]  put_row_nxt;
  logic [COL_W-1:0]  put_col_nxt;
  logic [ADDR_W+10:0] put_idx_ext;
  logic [ROW_W+4:0]  put_row_ext;
  logic [COL_W+6:0]  put_col_ext;
  logic [ROW_W+4:0]  row_ext;
  logic [COL_W+6:0]  col_ext;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  // Range check of the read index
  assign rd_wide     = (IDX_W + 1)'(in_beat.read_index);
  assign rd_in_range = rd_wide < (IDX_W + 1)'(CELL_COUNT);

  // Cursor update of a put
  assign put_char = (char_r != NEWLINE_CODE);
  assign put_idx  = ADDR_W'(row_r * SCREEN_WIDTH) + ADDR_W'(col_r);

  always_comb begin
    put_row_nxt = row_r;
    put_col_nxt = col_r + COL_W'(1);
    if (!put_char || col_r == COL_LAST) begin
      put_row_nxt = row_r + ROW_W'(1);
      put_col_nxt = '0;
    end
  end

  // Resize to the result field widths
  assign put_idx_ext = {11'd0, put_idx};
  assign put_row_ext = {5'd0, put_row_nxt};
  assign put_col_ext = {7'd0, put_col_nxt};
  assign row_ext     = {5'd0, row_r};
  assign col_ext     = {7'd0, col_r};

  // Select the store read address
  always_comb begin
    if (state_r == ST_IDLE) begin
      ram_raddr = rd_wide[ADDR_W-1:0];
    end else begin
      ram_raddr = cnt_r;
    end
  end

  // Select the store write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = CLEAR_CELL;
      end
      ST_SCROLL: begin
        ram_we    = pend_r;
        ram_waddr = pend_addr_r;
        ram_wdata = ram_rdata;
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (pend_r) begin
          ram_waddr = pend_addr_r;
          ram_wdata = ram_rdata;
        end
      end
      ST_PUT: begin
        ram_we    = put_char;
        ram_waddr = put_idx;
        ram_wdata = {color_r, char_r};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tcw_screen_ram #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Hold the attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= RESET_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      color_r <= cfg_data;
    end
  end

  // Sequencer: clear, scroll, fill, put and read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      cnt_r      <= '0;
      pend_r     <= 1'b0;
      row_r      <= '0;
      col_r      <= '0;
      scrolled_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          if (cnt_r == LAST_CELL) begin
            cnt_r   <= '0;
            state_r <= ST_IDLE;
          end else begin
            cnt_r <= cnt_r + ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            char_r     <= in_beat.char_code;
            rd_ok_r    <= rd_in_range;
            scrolled_r <= 1'b0;
            pend_r     <= 1'b0;
            if (in_beat.command == CMD_READ) begin
              state_r <= ST_READ;
            end else if (row_r == ROW_PEND) begin
              cnt_r   <= ROW_STEP;
              state_r <= ST_SCROLL;
            end else begin
              state_r <= ST_PUT;
            end
          end
        end
        ST_SCROLL: begin
          // Read one row below, write it in the next cycle
          pend_r      <= 1'b1;
          pend_addr_r <= ADDR_W'(cnt_r - ROW_STEP);
          if (cnt_r == LAST_CELL) begin
            cnt_r   <= FILL_START;
            state_r <= ST_FILL;
          end else begin
            cnt_r <= cnt_r + ADDR_W'(1);
          end
        end
        ST_FILL: begin
          if (pend_r) begin
            pend_r <= 1'b0;
          end else if (cnt_r == LAST_CELL) begin
            row_r      <= ROW_BOTTOM;
            scrolled_r <= 1'b1;
            state_r    <= ST_PUT;
          end else begin
            cnt_r <= cnt_r + ADDR_W'(1);
          end
        end
        ST_PUT: begin
          row_r                <= put_row_nxt;
          col_r                <= put_col_nxt;
          res_r.cell_written   <= put_char;
          res_r.cell_index     <= put_char ? put_idx_ext[10:0] : 11'd0;
          res_r.cell_data      <= put_char ? {color_r, char_r} : 16'd0;
          res_r.scrolled       <= scrolled_r;
          res_r.cursor_row     <= put_row_ext[4:0];
          res_r.cursor_column  <= put_col_ext[6:0];
          res_r.read_data      <= 16'd0;
          state_r              <= ST_DONE;
        end
        ST_READ: begin
          res_r.cell_written   <= 1'b0;
          res_r.cell_index     <= 11'd0;
          res_r.cell_data      <= 16'd0;
          res_r.scrolled       <= 1'b0;
          res_r.cursor_row     <= row_ext[4:0];
          res_r.cursor_column  <= col_ext[6:0];
          res_r.read_data      <= rd_ok_r ? ram_rdata : 16'd0;
          state_r              <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the result beat until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
      out_r <= res_r;
    end
  end

endmodule

[rtl/tcw_screen_ram.sv]
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [15:0]       wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [15:0]       rdata
);

  logic [15:0] mem [DEPTH];

  // Write and read the store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tcw_checker.sv]
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker
  import tcw_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_beat
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("result beat changed while stalled");

  // A stored cell is never a newline and comes with no read data
  a_written_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.cell_written |->
      out_beat.read_data == 16'd0 && out_beat.cell_data[7:0] != NEWLINE_CODE)
    else $error("written cell beat carries read data or a newline");

  // No stored cell means zero index and data
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_beat.cell_written |->
      out_beat.cell_index == 11'd0 && out_beat.cell_data == 16'd0)
    else $error("cell fields set without a write");

  // Keep the cursor on the screen, row may sit one past the bottom
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_beat.cursor_column) < SCREEN_WIDTH &&
                  int'(out_beat.cursor_row) <= SCREEN_HEIGHT)
    else $error("cursor out of range");

  // Drop any result beat at reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind text_console_writer tcw_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_beat  (out_beat)
);
